[rtl/core/aml_sts_pkg.sv]
`default_nettype none

package aml_sts_pkg;

	// default scan window after a name match, in bytes
	localparam int unsigned SEARCH_WINDOW_DEF = 32;

	// byte codes
	localparam logic [7:0] OP_PACKAGE  = 8'h12;
	localparam logic [7:0] BYTE_PREFIX = 8'h0A;
	localparam logic [7:0] LEN_MASK    = 8'hC0;
	localparam logic [7:0] CHAR_UNDER  = 8'h5F;
	localparam logic [7:0] CHAR_S      = 8'h53;
	localparam logic [7:0] CHAR_FIVE   = 8'h35;

	// defaults when the package is not located
	localparam logic [7:0] DEFAULT_A = 8'd5;
	localparam logic [7:0] DEFAULT_B = 8'd0;

	// minimum bytes after the opcode for a valid hit
	localparam logic [2:0] MIN_AFTER_OP = 3'd5;
	localparam logic [2:0] AFTER_OP_MAX = 3'd7;

	// decode phases of the scanner
	typedef enum logic [3:0] {
		PH_SEARCH = 4'd0,
		PH_LEAD   = 4'd1,
		PH_SKIP   = 4'd2,
		PH_COUNT  = 4'd3,
		PH_A      = 4'd4,
		PH_A_PRE  = 4'd5,
		PH_B      = 4'd6,
		PH_B_PRE  = 4'd7,
		PH_DONE   = 4'd8
	} phase_t;

	// one table byte request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_table;
	} scan_item_t;

	// one scan result
	typedef struct packed {
		logic       found;
		logic [7:0] sleep_type_a;
		logic [7:0] sleep_type_b;
	} scan_result_t;

	// expected character of the name at a given match position
	function automatic logic [7:0] name_char(input logic [1:0] pos);
		logic [7:0] c;
		case (pos)
			2'd0:    c = CHAR_UNDER;
			2'd1:    c = CHAR_S;
			2'd2:    c = CHAR_FIVE;
			default: c = CHAR_UNDER;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/aml_sts_in_reg.sv]
`default_nettype none

module aml_sts_in_reg
	import aml_sts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire scan_item_t in_item,
	input  wire logic       advance,
	output logic            in_ready,
	output logic            valid_s1,
	output scan_item_t      item_s1
);

	// stage may load when empty or when its request moves on
	assign in_ready = !valid_s1 || advance;

	// stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

[rtl/core/aml_sts_core.sv]
`default_nettype none

module aml_sts_core
	import aml_sts_pkg::*;
#(
	parameter int unsigned SEARCH_WINDOW = SEARCH_WINDOW_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire scan_item_t item_s1,
	output scan_result_t    result
);

	localparam int unsigned DW       = $clog2(SEARCH_WINDOW + 1);
	localparam int unsigned CLEAR_AT = SEARCH_WINDOW - 3;

	// scanner state
	logic [1:0]    name_prog_q, name_prog_d;
	logic          have_match_q, have_match_d;
	logic [DW-1:0] dist_q, dist_d;
	phase_t        phase_q, phase_d;
	logic [1:0]    skip_q, skip_d;
	logic [2:0]    after_op_q, after_op_d;
	logic [7:0]    val_a_q, val_a_d;
	logic [7:0]    val_b_q, val_b_d;

	logic [7:0]    b;
	logic [DW-1:0] dist_inc;
	logic          match_live;
	logic [1:0]    skip_dec;

	assign b = item_s1.data_byte;

	// next state for one byte
	always_comb begin
		name_prog_d  = name_prog_q;
		have_match_d = have_match_q;
		dist_d       = dist_q;
		phase_d      = phase_q;
		skip_d       = skip_q;
		after_op_d   = after_op_q;
		val_a_d      = val_a_q;
		val_b_d      = val_b_q;
		dist_inc     = dist_q;
		match_live   = have_match_q;
		skip_dec     = skip_q;

		if (phase_q == PH_SEARCH) begin
			// age the latest name match and drop it once its distance reaches SEARCH_WINDOW - 3
			if (have_match_q) begin
				if (dist_q < DW'(SEARCH_WINDOW)) begin
					dist_inc = dist_q + DW'(1);
				end
				if (dist_inc >= DW'(CLEAR_AT)) begin
					match_live = 1'b0;
				end
			end
			dist_d       = dist_inc;
			have_match_d = match_live;

			if (match_live && b == OP_PACKAGE) begin
				phase_d     = PH_LEAD;
				after_op_d  = 3'd0;
				name_prog_d = 2'd0;
			end else if (b == name_char(name_prog_q)) begin
				if (name_prog_q == 2'd3) begin
					have_match_d = 1'b1;
					dist_d       = '0;
					name_prog_d  = 2'd1;
				end else begin
					name_prog_d = name_prog_q + 2'd1;
				end
			end else begin
				name_prog_d = (b == CHAR_UNDER) ? 2'd1 : 2'd0;
			end
		end else begin
			// saturating count of bytes after the opcode
			if (after_op_q < AFTER_OP_MAX) begin
				after_op_d = after_op_q + 3'd1;
			end
			unique case (phase_q)
				PH_LEAD: begin
					if ((b & LEN_MASK) != 8'd0) begin
						skip_d  = b[7:6];
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_COUNT;
					end
				end
				PH_SKIP: begin
					if (skip_q != 2'd0) begin
						skip_dec = skip_q - 2'd1;
					end
					skip_d = skip_dec;
					if (skip_dec == 2'd0) begin
						phase_d = PH_COUNT;
					end
				end
				PH_COUNT: begin
					phase_d = PH_A;
				end
				PH_A: begin
					val_a_d = b;
					phase_d = (b == BYTE_PREFIX) ? PH_A_PRE : PH_B;
				end
				PH_A_PRE: begin
					val_a_d = b;
					phase_d = PH_B;
				end
				PH_B: begin
					val_b_d = b;
					phase_d = (b == BYTE_PREFIX) ? PH_B_PRE : PH_DONE;
				end
				PH_B_PRE: begin
					val_b_d = b;
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// result as seen after this byte
	always_comb begin
		result.found        = (phase_d != PH_SEARCH) && (after_op_d >= MIN_AFTER_OP);
		result.sleep_type_a = result.found ? val_a_d : DEFAULT_A;
		result.sleep_type_b = result.found ? val_b_d : DEFAULT_B;
	end

	// state registers, cleared at the end of each table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_prog_q  <= 2'd0;
			have_match_q <= 1'b0;
			dist_q       <= '0;
			phase_q      <= PH_SEARCH;
			skip_q       <= 2'd0;
			after_op_q   <= 3'd0;
			val_a_q      <= 8'd0;
			val_b_q      <= 8'd0;
		end else if (advance) begin
			if (item_s1.end_of_table) begin
				name_prog_q  <= 2'd0;
				have_match_q <= 1'b0;
				dist_q       <= '0;
				phase_q      <= PH_SEARCH;
				skip_q       <= 2'd0;
				after_op_q   <= 3'd0;
				val_a_q      <= 8'd0;
				val_b_q      <= 8'd0;
			end else begin
				name_prog_q  <= name_prog_d;
				have_match_q <= have_match_d;
				dist_q       <= dist_d;
				phase_q      <= phase_d;
				skip_q       <= skip_d;
				after_op_q   <= after_op_d;
				val_a_q      <= val_a_d;
				val_b_q      <= val_b_d;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/aml_sts_out_reg.sv]
`default_nettype none

module aml_sts_out_reg
	import aml_sts_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         valid_s1,
	input  wire logic         last_s1,
	input  wire scan_result_t result,
	input  wire logic         out_ready,
	output logic              advance,
	output logic              out_valid,
	output scan_result_t      out_result
);

	logic out_free;
	logic load;

	// a byte moves on unless it is the last one and the result slot is full
	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign load     = advance && last_s1;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_result <= result;
		end
	end

endmodule

`default_nettype wire

[rtl/core/aml_sleep_type_scanner_unit.sv]
// a last byte's request passes the input stage and then the result register before its result shows on m_tvalid
// throughput: one table byte per cycle, set by the single-byte scanner update, unless a last byte waits on m_tready
// the input stage keeps taking bytes while a result waits on m_tready, until it holds a last byte
// reset: arst_n clears the stages and the scanner to the searching phase
// the scanner also clears itself after every last byte
`default_nettype none

module aml_sleep_type_scanner_unit
	import aml_sts_pkg::*;
#(
	parameter int unsigned SEARCH_WINDOW = SEARCH_WINDOW_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,   // end_of_table
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] sleep_type_a, [15:8] sleep_type_b
	output logic             m_tuser    // found
);

	scan_item_t   in_item;
	scan_item_t   item_s1;
	scan_result_t result;
	scan_result_t out_result;
	logic         valid_s1;
	logic         advance;

	assign in_item.data_byte    = s_tdata;
	assign in_item.end_of_table = s_tlast;

	// input stage
	aml_sts_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_item  (in_item),
		.advance  (advance),
		.in_ready (s_tready),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// scanner state and byte update
	aml_sts_core #(
		.SEARCH_WINDOW (SEARCH_WINDOW)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	// result register
	aml_sts_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.last_s1    (item_s1.end_of_table),
		.result     (result),
		.out_ready  (m_tready),
		.advance    (advance),
		.out_valid  (m_tvalid),
		.out_result (out_result)
	);

	assign m_tdata = {out_result.sleep_type_b, out_result.sleep_type_a};
	assign m_tuser = out_result.found;

	// a miss always carries the default sleep types
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[7:0] == DEFAULT_A && m_tdata[15:8] == DEFAULT_B))
	else $error("miss result without default values");

	// input stalls only behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
	else $error("input stalled while result slot free");

	// a new result comes only from a last byte that moved on
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !$past(m_tvalid)) |-> $past(advance && item_s1.end_of_table))
	else $error("result without a last byte");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb
	import aml_sts_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BYTES = 800;
	localparam int DRAIN_CYCLES = 10;

	// one row of the directed table: the byte, its end flag, and a typed result if any
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		logic       found;
		logic [7:0] type_a;
		logic [7:0] type_b;
	} table_row_t;

	localparam int DIRECTED_ROWS = 29;
	localparam table_row_t DIRECTED[DIRECTED_ROWS] = '{
		// one-byte table, nothing to find
		'{8'hFF, 1'b1, 1'b1, 1'b0, DEFAULT_A, DEFAULT_B},
		// longest package length, prefix on the last byte, second value past the end
		'{CHAR_UNDER, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_S, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_FIVE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_UNDER, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{OP_PACKAGE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'hC3, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{BYTE_PREFIX, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{BYTE_PREFIX, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
		// too few bytes after the opcode
		'{CHAR_UNDER, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_S, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_FIVE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_UNDER, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{OP_PACKAGE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h00, 1'b1, 1'b1, 1'b0, DEFAULT_A, DEFAULT_B},
		// restarted name, one length byte, all-ones values
		'{CHAR_UNDER, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_UNDER, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_S, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_FIVE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{CHAR_UNDER, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{OP_PACKAGE, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h40, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00}
	};

	localparam logic [7:0] NAME_CHARS[4] = '{CHAR_UNDER, CHAR_S, CHAR_FIVE, CHAR_UNDER};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;

	// scanner copy used to predict each table's result
	logic [1:0]   name_pos;
	logic         name_seen;
	int unsigned  match_dist;
	phase_t       scan_phase;
	logic [1:0]   len_left;
	logic [2:0]   after_op;
	logic [7:0]   val_a;
	logic [7:0]   val_b;

	scan_result_t pending_scans[$];
	scan_result_t oldest_scan;
	int           mismatch_count;
	int           cycle_count;
	int           bytes_sent;
	int           send_idle_pct;
	int           recv_stall_pct;

	aml_sleep_type_scanner_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clear the scanner copy for the next table
	task automatic clear_scan();
		name_pos = 2'd0;
		name_seen = 1'b0;
		match_dist = 0;
		scan_phase = PH_SEARCH;
		len_left = 2'd0;
		after_op = 3'd0;
		val_a = 8'd0;
		val_b = 8'd0;
	endtask

	// advance the scanner copy by one accepted byte; emit on the last byte
	task automatic scan_table_byte(input logic [7:0] b, input logic last,
			output logic emit, output scan_result_t res);
		logic hit;
		if (scan_phase == PH_SEARCH) begin
			if (name_seen) begin
				if (match_dist < SEARCH_WINDOW_DEF)
					match_dist++;
				if (match_dist + 4 > SEARCH_WINDOW_DEF)
					name_seen = 1'b0;
			end
			if (name_seen && b == OP_PACKAGE) begin
				scan_phase = PH_LEAD;
				after_op = 3'd0;
				name_pos = 2'd0;
			end else if (b == NAME_CHARS[name_pos]) begin
				if (name_pos == 2'd3) begin
					name_seen = 1'b1;
					match_dist = 0;
					name_pos = 2'd1;
				end else begin
					name_pos = name_pos + 2'd1;
				end
			end else begin
				name_pos = (b == CHAR_UNDER) ? 2'd1 : 2'd0;
			end
		end else begin
			if (after_op < AFTER_OP_MAX)
				after_op = after_op + 3'd1;
			case (scan_phase)
				PH_LEAD: begin
					if ((b & LEN_MASK) != 8'd0) begin
						len_left = b[7:6];
						scan_phase = PH_SKIP;
					end else begin
						scan_phase = PH_COUNT;
					end
				end
				PH_SKIP: begin
					if (len_left != 2'd0)
						len_left = len_left - 2'd1;
					if (len_left == 2'd0)
						scan_phase = PH_COUNT;
				end
				PH_COUNT: scan_phase = PH_A;
				PH_A: begin
					val_a = b;
					scan_phase = (b == BYTE_PREFIX) ? PH_A_PRE : PH_B;
				end
				PH_A_PRE: begin
					val_a = b;
					scan_phase = PH_B;
				end
				PH_B: begin
					val_b = b;
					scan_phase = (b == BYTE_PREFIX) ? PH_B_PRE : PH_DONE;
				end
				PH_B_PRE: begin
					val_b = b;
					scan_phase = PH_DONE;
				end
				default: ;
			endcase
		end
		emit = last;
		res = '0;
		if (last) begin
			hit = (scan_phase != PH_SEARCH) && (after_op >= MIN_AFTER_OP);
			res.found = hit;
			res.sleep_type_a = hit ? val_a : DEFAULT_A;
			res.sleep_type_b = hit ? val_b : DEFAULT_B;
			clear_scan();
		end
	endtask

	// present one byte request, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
			input scan_result_t want);
		logic emit;
		scan_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		scan_table_byte(b, last, emit, res);
		if (emit)
			pending_scans.push_back(typed ? want : res);
	endtask

	// byte drawn mostly from the codes the scanner reacts to
	function automatic logic [7:0] biased_byte();
		logic [7:0] b;
		case ($urandom_range(5))
			0: b = CHAR_UNDER;
			1: b = CHAR_S;
			2: b = CHAR_FIVE;
			3: b = OP_PACKAGE;
			4: b = BYTE_PREFIX;
			default: b = 8'($urandom_range(255));
		endcase
		return b;
	endfunction

	// one random table: mostly well-formed packages, some noise, cut-off and one-byte tables
	task automatic random_table();
		logic [7:0] tbl[$];
		logic [7:0] lead;
		int kind;
		int n;
		int cut;
		kind = $urandom_range(9);
		if (kind <= 6) begin
			n = $urandom_range(4);
			repeat (n) tbl.push_back(8'($urandom_range(255)));
			tbl.push_back(CHAR_UNDER);
			tbl.push_back(CHAR_S);
			tbl.push_back(CHAR_FIVE);
			tbl.push_back(CHAR_UNDER);
			// overlapping second name
			if ($urandom_range(3) == 0) begin
				tbl.push_back(CHAR_S);
				tbl.push_back(CHAR_FIVE);
				tbl.push_back(CHAR_UNDER);
			end
			// gap before the opcode, sometimes past the window
			n = ($urandom_range(7) == 0) ? $urandom_range(20, 32) : $urandom_range(4);
			repeat (n) tbl.push_back(biased_byte());
			tbl.push_back(OP_PACKAGE);
			lead = 8'($urandom_range(255));
			tbl.push_back(lead);
			repeat (lead[7:6]) tbl.push_back(8'($urandom_range(255)));
			tbl.push_back(8'($urandom_range(255)));
			repeat (2) begin
				if ($urandom_range(2) == 0)
					tbl.push_back(BYTE_PREFIX);
				tbl.push_back(8'($urandom_range(255)));
			end
			n = $urandom_range(3);
			repeat (n) tbl.push_back(biased_byte());
			if ($urandom_range(3) == 0) begin
				cut = $urandom_range(1, tbl.size());
				while (tbl.size() > cut)
					void'(tbl.pop_back());
			end
		end else if (kind <= 8) begin
			n = $urandom_range(1, 24);
			repeat (n) tbl.push_back(biased_byte());
		end else begin
			tbl.push_back(8'($urandom_range(255)));
		end
		foreach (tbl[i]) begin
			send_byte(tbl[i], i == tbl.size() - 1, 1'b0, '0);
			bytes_sent++;
		end
	endtask

	// receiver stalls
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_scans.size() == 0) begin
				$error("result with none expected: found %0d a %0h b %0h",
					m_tuser, m_tdata[7:0], m_tdata[15:8]);
				mismatch_count++;
			end else begin
				oldest_scan = pending_scans.pop_front();
				if (m_tuser !== oldest_scan.found) begin
					$error("found: expected %0d, got %0d", oldest_scan.found, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[7:0] !== oldest_scan.sleep_type_a) begin
					$error("sleep_type_a: expected %0h, got %0h",
						oldest_scan.sleep_type_a, m_tdata[7:0]);
					mismatch_count++;
				end
				if (m_tdata[15:8] !== oldest_scan.sleep_type_b) begin
					$error("sleep_type_b: expected %0h, got %0h",
						oldest_scan.sleep_type_b, m_tdata[15:8]);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("aml_sleep_type_scanner_unit: mismatch");
			$finish;
		end
	end

	initial begin
		scan_result_t typed_res;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		bytes_sent = 0;
		send_idle_pct = 10;
		recv_stall_pct = 54;
		clear_scan();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed tables
		foreach (DIRECTED[i]) begin
			typed_res.found = DIRECTED[i].found;
			typed_res.sleep_type_a = DIRECTED[i].type_a;
			typed_res.sleep_type_b = DIRECTED[i].type_b;
			send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, typed_res);
		end

		// random tables through three idle patterns
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent >= 2 * RANDOM_BYTES / 3) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else if (bytes_sent >= RANDOM_BYTES / 3) begin
				send_idle_pct = 54;
				recv_stall_pct = 10;
			end
			random_table();
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("aml_sleep_type_scanner_unit: match");
		else
			$display("aml_sleep_type_scanner_unit: mismatch");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/aml_sts_pkg.sv
rtl/core/aml_sts_in_reg.sv
rtl/core/aml_sts_core.sv
rtl/core/aml_sts_out_reg.sv
rtl/core/aml_sleep_type_scanner_unit.sv
tb/sv/tb.sv
